// ----- hdl/gse_pkg.sv -----
// Shared types and constants of the gray Sobel edge magnitude block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package gse_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int WidW     = 11;
  localparam int HgtW     = 12;
  localparam int RowW     = HgtW + 1;
  localparam int CntW     = 22;
  localparam int CfgW     = 12;
  localparam int SumW     = 21;

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  // Q0.16 luma weights
  localparam logic [16:0] GrayR = 17'd19661;
  localparam logic [16:0] GrayG = 17'd38666;
  localparam logic [16:0] GrayB = 17'd7209;

  localparam logic [SumW-1:0] SatSq = SumW'(65025);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_SQX  = 6'b000100,
    ST_SQY  = 6'b001000,
    ST_ROOT = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  typedef struct packed {
    logic accept;
    logic load;
    logic sqx;
    logic sqy;
    logic root;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic emit;
    logic root_done;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/gse_ctrl.sv -----
// Sequencer of the edge magnitude block: accept, window load, squares, root, output.
// Depends on gse_pkg.
`timescale 1ns / 1ps
module gse_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  gse_pkg::sts_t sts_i,
  output gse_pkg::cmd_t cmd_o
);
  import gse_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = s_axis_tvalid;
        if (s_axis_tvalid && !sts_i.drop) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d = sts_i.emit ? ST_SQX : ST_IDLE;
      end
      ST_SQX: begin
        cmd_o.sqx = 1'b1;
        state_d = ST_SQY;
      end
      ST_SQY: begin
        cmd_o.sqy = 1'b1;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root = 1'b1;
        if (sts_i.root_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/gse_dpath.sv -----
// Datapath: gray conversion, line stores, 3x3 window, Sobel gradients, root unit, output reg.
// Depends on gse_pkg.
`timescale 1ns / 1ps
module gse_dpath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [gse_pkg::CfgW-1:0] cfg_data_i,
  input  logic [23:0]              s_axis_tdata,
  input  logic                     s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,
  output logic                     m_axis_tlast,
  input  gse_pkg::cmd_t            cmd_i,
  output gse_pkg::sts_t            sts_o
);
  import gse_pkg::*;

  logic [WidW-1:0] width_q;
  logic [HgtW-1:0] height_q;
  logic [CntW-1:0] total_q;
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic [CntW-1:0] out_count_q;
  logic [7:0]      win_q [6];
  logic [7:0]      gray_q;
  logic [7:0]      rd_up_q, rd_lo_q;
  logic [7:0]      mem_up [MaxWidth];
  logic [7:0]      mem_lo [MaxWidth];
  logic signed [11:0] gx_q, gy_q;
  logic            last_q;
  logic [SumW-1:0] sq_q, sum_q;
  logic [7:0]      k_q, bit_q;
  logic            out_valid_q, out_last_q;
  logic [7:0]      out_data_q;

  logic [WidW-1:0] w_eff;
  logic [HgtW-1:0] h_eff;
  logic [ColW-1:0] col_eff;
  logic            in_frame;
  logic [23:0]     gray_full;
  logic [7:0]      f0, f1, r0, r1, r2;
  logic            col0, emit_d, last_d;
  logic [9:0]      sxr, sxl, syb, syt;
  logic [7:0]      t;
  logic [15:0]     tt;
  logic            out_free;

  always_comb begin
    if (width_q == '0) w_eff = WidW'(1);
    else if (width_q > WidW'(MaxWidth)) w_eff = WidW'(MaxWidth);
    else w_eff = width_q;
    h_eff = (height_q == '0) ? HgtW'(1) : height_q;
    col_eff = ({1'b0, col_q} >= w_eff) ? ColW'(w_eff - WidW'(1)) : col_q;
  end

  assign in_frame  = row_q < {1'b0, h_eff};
  assign gray_full = GrayR * s_axis_tdata[7:0] + GrayG * s_axis_tdata[15:8]
                   + GrayB * s_axis_tdata[23:16];

  // rows above the frame, and rows past its end, read as zero
  assign f0   = (row_q >= RowW'(2) && (row_q - RowW'(2)) < {1'b0, h_eff}) ? rd_up_q : 8'd0;
  assign f1   = (row_q >= RowW'(1) && (row_q - RowW'(1)) < {1'b0, h_eff}) ? rd_lo_q : 8'd0;
  assign col0 = (col_q == '0);
  assign r0   = col0 ? 8'd0 : f0;
  assign r1   = col0 ? 8'd0 : f1;
  assign r2   = col0 ? 8'd0 : gray_q;
  assign emit_d = col0 ? (row_q >= RowW'(2)) : (row_q >= RowW'(1));
  assign last_d = (out_count_q + CntW'(1)) == total_q;

  assign sxr = 10'(r0) + {1'b0, r1, 1'b0} + 10'(r2);
  assign sxl = 10'(win_q[0]) + {1'b0, win_q[1], 1'b0} + 10'(win_q[2]);
  assign syb = 10'(win_q[2]) + {1'b0, win_q[5], 1'b0} + 10'(r2);
  assign syt = 10'(win_q[0]) + {1'b0, win_q[3], 1'b0} + 10'(r0);

  assign t  = k_q | bit_q;
  assign tt = t * t;

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    sts_o.drop      = s_axis_tuser && in_frame;
    sts_o.emit      = emit_d;
    sts_o.root_done = bit_q[0];
    sts_o.out_free  = out_free;
  end

  // line stores, registered read at the current column
  always_ff @(posedge clk_i) begin
    rd_up_q <= mem_up[col_eff];
    rd_lo_q <= mem_lo[col_eff];
    if (cmd_i.load && in_frame) begin
      mem_up[col_eff] <= rd_lo_q;
      mem_lo[col_eff] <= in_frame ? gray_q : 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) gray_q <= in_frame ? gray_full[23:16] : 8'd0;
    total_q <= CntW'(w_eff) * CntW'(h_eff);
    if (cmd_i.load) begin
      gx_q   <= $signed({2'b00, sxr}) - $signed({2'b00, sxl});
      gy_q   <= $signed({2'b00, syb}) - $signed({2'b00, syt});
      last_q <= last_d;
    end
    if (cmd_i.sqx) sq_q <= SumW'(gx_q) * SumW'(gx_q);
    if (cmd_i.sqy) begin
      sum_q <= sq_q + SumW'(gy_q) * SumW'(gy_q);
      k_q   <= 8'd0;
      bit_q <= 8'h80;
    end
    if (cmd_i.root) begin
      if (SumW'(tt) <= sum_q) k_q <= t;
      bit_q <= bit_q >> 1;
    end
    if (cmd_i.push) begin
      out_data_q <= (sum_q >= SatSq) ? 8'd255 : k_q;
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WidW'(1024);
      height_q    <= HgtW'(768);
      col_q       <= '0;
      row_q       <= '0;
      out_count_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 6; i++) win_q[i] <= 8'd0;
    end else begin
      if (cmd_i.push) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegWidth) width_q <= cfg_data_i[WidW-1:0];
        else height_q <= cfg_data_i[HgtW-1:0];
        col_q       <= '0;
        row_q       <= '0;
        out_count_q <= '0;
        for (int i = 0; i < 6; i++) win_q[i] <= 8'd0;
      end else if (cmd_i.load) begin
        if (emit_d && last_d) begin
          col_q       <= '0;
          row_q       <= '0;
          out_count_q <= '0;
          for (int i = 0; i < 6; i++) win_q[i] <= 8'd0;
        end else begin
          if (emit_d) out_count_q <= out_count_q + CntW'(1);
          if ({1'b0, col_eff} + WidW'(1) >= w_eff) begin
            col_q <= '0;
            row_q <= row_q + RowW'(1);
          end else begin
            col_q <= col_eff + ColW'(1);
          end
          win_q[0] <= col0 ? 8'd0 : win_q[3];
          win_q[1] <= col0 ? 8'd0 : win_q[4];
          win_q[2] <= col0 ? 8'd0 : win_q[5];
          win_q[3] <= f0;
          win_q[4] <= f1;
          win_q[5] <= gray_q;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  a_count_below_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_count_q < total_q) else $error("output count reached frame size");

  a_col_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < w_eff) else $error("column beyond line width");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && emit_d && last_d) |=>
      (col_q == '0 && row_q == '0 && out_count_q == '0))
    else $error("frame did not restart after last item");

endmodule

// ----- hdl/gray_sobel_edge_magnitude.sv -----
// Top level of the gray Sobel edge magnitude block.
// Depends on gse_pkg, gse_ctrl and gse_dpath.
`timescale 1ns / 1ps
// Takes RGB items in raster order, converts each to gray, and emits the
// saturated Sobel gradient magnitude of the image one line plus one pixel
// behind, with tlast on the final pixel of the frame; after a frame send
// img_width + 1 flush items (tuser = 1) to push out the rest. One item is
// in work at a time: an item that yields no result stops at or before the
// window load, one that yields a result goes through the window load, the
// squaring of gx and of gy and an 8-step bit-serial square root, plus any
// wait on the output register. Configuration writes restart the frame.
module gray_sobel_edge_magnitude (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [gse_pkg::CfgW-1:0] cfg_data_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [23:0]              s_axis_tdata,  // red, green, blue
  input  logic                     s_axis_tuser,  // kind
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [7:0]               m_axis_tdata,  // edge_res
  output logic                     m_axis_tlast
);
  import gse_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gse_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  gse_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
